>>> hw/rtl/maze_backtracker_generator_assert.svh
// Assertion macros for the maze generator.
`ifndef MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH
`define MAZE_BACKTRACKER_GENERATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MBG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define MBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> hw/rtl/mbg_pkg.sv
// Package: sizes, field widths, opcodes, frame type and LFSR step of the maze generator.
`default_nettype none
package mbg_pkg;
    localparam int MaxCols    = 128;
    localparam int MaxRows    = 32;
    localparam int StackDepth = 1024;
    localparam int ColW   = $clog2(MaxCols);
    localparam int RowW   = $clog2(MaxRows);
    localparam int CellAw = ColW + RowW;
    localparam int SpW    = $clog2(StackDepth) + 1;
    localparam int StkAw  = $clog2(StackDepth);
    localparam logic [31:0] LfsrTaps = 32'h8020_0003;
    localparam logic ActGenerate = 1'b0;
    localparam logic ActRead     = 1'b1;
    localparam logic [1:0] RegCols = 2'd0;
    localparam logic [1:0] RegRows = 2'd1;
    localparam logic [1:0] RegSeed = 2'd2;
    localparam logic [1:0] DirN = 2'd0;
    localparam logic [1:0] DirE = 2'd1;
    localparam logic [1:0] DirS = 2'd2;
    localparam logic [1:0] DirW = 2'd3;

    // One stack frame: position, direction order, next index.
    typedef struct packed {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
        logic [7:0]      order;
        logic [2:0]      next;
    } frame_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        lfsr_step = v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/maze_backtracker_generator.sv
// Top level: maze grid memory, walk stack memory and carve sequencer.
// Read beat: after acceptance the cell is read into the memory read register, then the output register raises tvalid.
// Generate beat: clearing sweep of MaxCols*MaxRows = 4096 cells, then per direction a look
// plus a target read if on the grid with stack room; a move adds open, push and four draws;
// a pop reads the new top. One beat at a time; a waiting result holds input.
// Reset (aresetn low, synchronous): registers 79/23/1, LFSR 1, then all 4096 cells walled.
`default_nettype none
module maze_backtracker_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: action[0], col[7:1], row[12:8], zeros[15:13]
    input  wire logic [15:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: is_passage[0], status[1], zeros[7:2]
    output logic [7:0]       m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mbg_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_PUSH, ST_SHUF, ST_TOP, ST_TOPW, ST_LOOK,
        ST_LOOKW, ST_OPEN, ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic [7:0]  cols_reg;
    logic [5:0]  rows_reg;
    logic [31:0] seed_reg;
    logic [31:0] lfsr_reg, lfsr_next;
    logic [SpW-1:0] sp_reg, sp_next;
    logic [CellAw-1:0] clr_reg, clr_next;
    logic [1:0]  idx_reg, idx_next;
    frame_t      fr_reg, fr_next;
    logic [ColW-1:0] tcol_reg, tcol_next, mcol_reg, mcol_next;
    logic [RowW-1:0] trow_reg, trow_next, mrow_reg, mrow_next;
    logic        gen_reg, gen_next;
    logic        mv_reg, mv_next;
    logic [1:0]  md_reg, md_next;

    // Cell memory and stack memory, one port each.
    logic cell_mem [MaxCols*MaxRows];
    logic cell_rd_reg;
    logic cell_we, cell_wd;
    logic [CellAw-1:0] cell_a;
    frame_t stk_mem [StackDepth];
    frame_t stk_rd_reg;
    logic stk_we;
    logic [StkAw-1:0] stk_a;
    frame_t stk_wd;

    always_ff @(posedge aclk) begin
        if (cell_we) begin
            cell_mem[cell_a] <= cell_wd;
        end
        cell_rd_reg <= cell_mem[cell_a];
        if (stk_we) begin
            stk_mem[stk_a] <= stk_wd;
        end
        stk_rd_reg <= stk_mem[stk_a];
    end

    // Sizes saturated at the grid bounds.
    logic [10:0] cols_eff, rows_eff;
    assign cols_eff = (11'(cols_reg) > 11'(MaxCols)) ? 11'(MaxCols) : 11'(cols_reg);
    assign rows_eff = (11'(rows_reg) > 11'(MaxRows)) ? 11'(MaxRows) : 11'(rows_reg);

    logic s_hs, m_hs, cfg_wr;
    logic in_act;
    logic [ColW-1:0] in_col;
    logic [RowW-1:0] in_row;
    logic in_inside;
    assign s_hs   = s_tvalid && s_tready;
    assign m_hs   = m_tvalid && m_tready;
    assign in_act = s_tdata[0];
    assign in_col = s_tdata[7:1];
    assign in_row = s_tdata[12:8];
    assign in_inside = (11'(in_col) < cols_eff) && (11'(in_row) < rows_eff);
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            RegCols: prdata = {24'd0, cols_reg};
            RegRows: prdata = {26'd0, rows_reg};
            RegSeed: prdata = seed_reg;
            default: prdata = 32'd0;
        endcase
    end

    // Current direction and its two-step target.
    logic [1:0]  dir;
    logic [11:0] x2, y2;
    logic        tgt_in;
    always_comb begin
        dir = fr_reg.order[2*fr_reg.next[1:0] +: 2];
        x2 = 12'(fr_reg.col);
        y2 = 12'(fr_reg.row);
        case (dir)
            DirN: y2 = y2 - 12'd2;
            DirE: x2 = x2 + 12'd2;
            DirS: y2 = y2 + 12'd2;
            default: x2 = x2 - 12'd2;
        endcase
        tgt_in = !x2[11] && !y2[11] && (x2[10:0] < cols_eff) && (y2[10:0] < rows_eff);
    end

    logic [1:0] r2;
    logic [7:0] ord_sw;
    logic [31:0] lfsr_adv;
    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign r2 = lfsr_adv[1:0];
    always_comb begin
        ord_sw = fr_reg.order;
        ord_sw[2*r2 +: 2]      = fr_reg.order[2*idx_reg +: 2];
        ord_sw[2*idx_reg +: 2] = fr_reg.order[2*r2 +: 2];
    end

    always_comb begin
        state_next = state_reg;
        lfsr_next = lfsr_reg;
        sp_next = sp_reg;
        clr_next = clr_reg;
        idx_next = idx_reg;
        fr_next = fr_reg;
        tcol_next = tcol_reg;
        trow_next = trow_reg;
        mcol_next = mcol_reg;
        mrow_next = mrow_reg;
        gen_next = gen_reg;
        mv_next = mv_reg;
        md_next = md_reg;
        cell_we = 1'b0;
        cell_wd = 1'b0;
        cell_a = {trow_reg, tcol_reg};
        stk_we = 1'b0;
        stk_a = sp_reg[StkAw-1:0];
        stk_wd = fr_reg;
        if (m_hs) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                cell_a = clr_reg;
                cell_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = gen_reg ? ST_PUSH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                cell_a = {in_row, in_col};
                if (s_hs) begin
                    tcol_next = in_col;
                    trow_next = in_row;
                    if (!in_inside) begin
                        mv_next = 1'b1;
                        md_next = 2'b10;
                    end else if (in_act == ActRead) begin
                        state_next = ST_READ;
                    end else begin
                        gen_next = 1'b1;
                        lfsr_next = (seed_reg == 32'd0) ? 32'd1 : seed_reg;
                        sp_next = '0;
                        clr_next = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_READ: begin
                mv_next = 1'b1;
                md_next = {1'b0, cell_rd_reg};
                state_next = ST_IDLE;
            end
            ST_PUSH: begin
                // Open the cell and build a fresh frame.
                cell_we = 1'b1;
                cell_wd = 1'b1;
                fr_next.col = tcol_reg;
                fr_next.row = trow_reg;
                fr_next.order = 8'b11_10_01_00;
                fr_next.next = 3'd0;
                idx_next = 2'd0;
                state_next = ST_SHUF;
            end
            ST_SHUF: begin
                lfsr_next = lfsr_adv;
                fr_next.order = ord_sw;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = ST_LOOK;
                end
            end
            ST_TOP: begin
                stk_a = StkAw'(sp_reg - 1'b1);
                state_next = ST_TOPW;
            end
            ST_TOPW: begin
                fr_next = stk_rd_reg;
                state_next = ST_LOOK;
            end
            ST_LOOK: begin
                // fr_reg is the top frame; its updates reach memory only when a move saves it.
                if (fr_reg.next[2]) begin
                    sp_next = sp_reg - 1'b1;
                    state_next = (sp_reg == SpW'(1)) ? ST_RESP : ST_TOP;
                end else begin
                    fr_next.next = fr_reg.next + 3'd1;
                    tcol_next = x2[ColW-1:0];
                    trow_next = y2[RowW-1:0];
                    mcol_next = ColW'((12'(fr_reg.col) + x2) >> 1);
                    mrow_next = RowW'((12'(fr_reg.row) + y2) >> 1);
                    if (tgt_in && (sp_reg < SpW'(StackDepth))) begin
                        cell_a = {y2[RowW-1:0], x2[ColW-1:0]};
                        state_next = ST_LOOKW;
                    end
                end
            end
            ST_LOOKW: begin
                if (cell_rd_reg) begin
                    state_next = ST_LOOK;
                end else begin
                    // Save the updated frame and open the middle cell together.
                    stk_we = 1'b1;
                    stk_a = StkAw'(sp_reg - 1'b1);
                    cell_we = 1'b1;
                    cell_wd = 1'b1;
                    cell_a = {mrow_reg, mcol_reg};
                    state_next = ST_OPEN;
                end
            end
            ST_OPEN: begin
                sp_next = sp_reg + 1'b1;
                state_next = ST_PUSH;
            end
            ST_RESP: begin
                gen_next = 1'b0;
                mv_next = 1'b1;
                md_next = 2'b00;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        // The first frame counts as pushed once built.
        if (state_reg == ST_SHUF && idx_reg == 2'd3 && sp_reg == '0) begin
            sp_next = SpW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cols_reg <= 8'd79;
            rows_reg <= 6'd23;
            seed_reg <= 32'd1;
            lfsr_reg <= 32'd1;
            sp_reg <= '0;
            clr_reg <= '0;
            gen_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            lfsr_reg <= lfsr_next;
            sp_reg <= sp_next;
            clr_reg <= clr_next;
            gen_reg <= gen_next;
            mv_reg <= mv_next;
            if (cfg_wr) begin
                case (paddr[3:2])
                    RegCols: cols_reg <= pwdata[7:0];
                    RegRows: rows_reg <= pwdata[5:0];
                    RegSeed: seed_reg <= pwdata;
                    default: ;
                endcase
            end
        end
        idx_reg <= idx_next;
        fr_reg <= fr_next;
        tcol_reg <= tcol_next;
        trow_reg <= trow_next;
        mcol_reg <= mcol_next;
        mrow_reg <= mrow_next;
        md_reg <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata = {6'd0, md_reg};

`include "maze_backtracker_generator_assert.svh"
    `MBG_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= SpW'(StackDepth), "stack overflow")
    `MBG_ASSERT_IMP(a_busy, state_reg != ST_IDLE, !s_tready, "ready while busy")
    `MBG_ASSERT_NEXT(a_done, state_reg == ST_RESP, m_tvalid, "generate lost result")
endmodule
`default_nettype wire

>>> test/tb_maze_backtracker_generator.sv
// Testbench for the maze generator: stream stimulus, APB setup, in-bench maze predictor.
`default_nettype none
module tb_maze_backtracker_generator;
    import mbg_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tdata: action[0], col[7:1], row[12:8], zeros[15:13]
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata: is_passage[0], status[1], zeros[7:2]
    logic [7:0]  m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    maze_backtracker_generator dut (.*);

    always #5 aclk = ~aclk;

    // Shadow of the block: grid, registers and carve stack.
    logic        grid_shadow [MaxCols*MaxRows];
    logic [7:0]  cols_reg;
    logic [5:0]  rows_reg;
    logic [31:0] seed_reg;
    logic [31:0] carve_lfsr;

    typedef struct {
        int         c;
        int         r;
        logic [1:0] ord [4];
        int         nxt;
    } carve_frame_t;
    carve_frame_t carve_stack [StackDepth];
    int           carve_sp;

    typedef struct packed {
        logic is_passage;
        logic status;
    } cell_answer_t;
    cell_answer_t answers_due [$];

    int send_idle_pct, recv_idle_pct;
    int mismatches;
    int hold_off_cycles;
    bit failed;

    function automatic int cols_eff();
        return (cols_reg > MaxCols) ? MaxCols : int'(cols_reg);
    endfunction

    function automatic int rows_eff();
        return (rows_reg > MaxRows) ? MaxRows : int'(rows_reg);
    endfunction

    function automatic logic [1:0] next_draw();
        carve_lfsr = carve_lfsr[0] ? ((carve_lfsr >> 1) ^ LfsrTaps) : (carve_lfsr >> 1);
        return carve_lfsr[1:0];
    endfunction

    function automatic void open_and_push(int c, int r);
        logic [1:0] t, k;
        grid_shadow[r*MaxCols + c] = 1'b1;
        carve_stack[carve_sp].c = c;
        carve_stack[carve_sp].r = r;
        for (int i = 0; i < 4; i++) carve_stack[carve_sp].ord[i] = 2'(i);
        for (int i = 0; i < 4; i++) begin
            k = next_draw();
            t = carve_stack[carve_sp].ord[k];
            carve_stack[carve_sp].ord[k] = carve_stack[carve_sp].ord[i];
            carve_stack[carve_sp].ord[i] = t;
        end
        carve_stack[carve_sp].nxt = 0;
        carve_sp++;
    endfunction

    // Depth-first carve from the start cell, as the block does it.
    function automatic void carve_maze(int c0, int r0);
        int cw, rh, x2, y2, dx, dy;
        logic [1:0] d;
        cw = cols_eff();
        rh = rows_eff();
        foreach (grid_shadow[i]) grid_shadow[i] = 1'b0;
        carve_lfsr = (seed_reg == 0) ? 32'd1 : seed_reg;
        carve_sp = 0;
        open_and_push(c0, r0);
        while (carve_sp > 0) begin
            if (carve_stack[carve_sp-1].nxt >= 4) begin
                carve_sp--;
                continue;
            end
            d = carve_stack[carve_sp-1].ord[carve_stack[carve_sp-1].nxt];
            carve_stack[carve_sp-1].nxt++;
            dx = (d == DirE) ? 1 : (d == DirW) ? -1 : 0;
            dy = (d == DirS) ? 1 : (d == DirN) ? -1 : 0;
            x2 = carve_stack[carve_sp-1].c + 2*dx;
            y2 = carve_stack[carve_sp-1].r + 2*dy;
            if (x2 < 0 || x2 >= cw || y2 < 0 || y2 >= rh) continue;
            if (grid_shadow[y2*MaxCols + x2]) continue;
            if (carve_sp >= StackDepth) continue;
            grid_shadow[(y2-dy)*MaxCols + (x2-dx)] = 1'b1;
            open_and_push(x2, y2);
        end
    endfunction

    function automatic cell_answer_t predict_cell(logic act, int c, int r);
        cell_answer_t a;
        bit in_grid;
        in_grid = (c < cols_eff()) && (r < rows_eff());
        a.status = !in_grid;
        a.is_passage = 1'b0;
        if (in_grid) begin
            if (act == ActGenerate) carve_maze(c, r);
            else a.is_passage = grid_shadow[r*MaxCols + c];
        end
        return a;
    endfunction

    // Send one beat; predict on acceptance. Drop tvalid only while idling.
    task automatic send_cell_op(logic act, int c, int r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, 5'(r), 7'(c), act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        answers_due.push_back(predict_cell(act, c, r));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            RegCols: cols_reg = val[7:0];
            RegRows: rows_reg = val[5:0];
            default: seed_reg = val;
        endcase
        @(posedge aclk);
    endtask

    // Wait for every answer, then let the block settle before touching registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic read_all_cells();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 8; c++) send_cell_op(ActRead, c, r);
    endtask

    // Result side: drive tready with stalls, check each beat against the oldest answer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    cell_answer_t a;
                    a = answers_due.pop_front();
                    if (m_tdata[0] !== a.is_passage || m_tdata[1] !== a.status
                            || m_tdata[7:2] !== 6'd0) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected passage %0b status %0b, got %h",
                                     a.is_passage, a.status, m_tdata);
                    end
                end
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic test_directed();
        // Reset sizes: generate, read edges, outside cases.
        send_cell_op(ActGenerate, 0, 0);
        send_cell_op(ActRead, 0, 0);
        send_cell_op(ActRead, 78, 22);
        send_cell_op(ActRead, 79, 0);
        send_cell_op(ActRead, 127, 31);
        send_cell_op(ActGenerate, 127, 31);
        send_cell_op(ActRead, 2, 0);
        send_cell_op(ActGenerate, 78, 22);
        send_cell_op(ActRead, 77, 22);
        drain();
        // Zero seed and sizes above the parameters saturate.
        write_reg(RegSeed, 32'd0);
        write_reg(RegCols, 32'd255);
        write_reg(RegRows, 32'd63);
        send_cell_op(ActGenerate, 127, 31);
        send_cell_op(ActRead, 127, 31);
        send_cell_op(ActRead, 126, 31);
        send_cell_op(ActRead, 0, 0);
        drain();
        // Tiny grids.
        write_reg(RegCols, 32'd0);
        send_cell_op(ActGenerate, 0, 0);
        send_cell_op(ActRead, 0, 0);
        drain();
        write_reg(RegCols, 32'd2);
        write_reg(RegRows, 32'd1);
        write_reg(RegSeed, 32'hFFFF_FFFF);
        send_cell_op(ActGenerate, 1, 0);
        send_cell_op(ActRead, 1, 0);
        send_cell_op(ActRead, 0, 0);
        send_cell_op(ActRead, 1, 1);
        drain();
    endtask

    task automatic test_random_mazes(int n);
        int c, r;
        for (int i = 0; i < n; i++) begin
            if (i % 12 == 0) begin
                drain();
                write_reg(RegCols, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                           : $urandom_range(3, 16));
                write_reg(RegRows, ($urandom_range(3) == 0) ? $urandom_range(63)
                                                           : $urandom_range(3, 12));
                write_reg(RegSeed, $urandom);
                send_cell_op(ActGenerate, $urandom_range(cols_eff() > 0 ? cols_eff()-1 : 0),
                             $urandom_range(rows_eff() > 0 ? rows_eff()-1 : 0));
            end else begin
                c = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(16);
                r = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(12);
                send_cell_op(($urandom_range(9) == 0) ? ActGenerate : ActRead, c, r);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        // Hold the result side off while reads keep coming.
        write_reg(RegCols, 32'd12);
        write_reg(RegRows, 32'd9);
        write_reg(RegSeed, 32'h1234_5678);
        send_cell_op(ActGenerate, 5, 4);
        drain();
        hold_off_cycles = 300;
        read_all_cells();
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        cols_reg = 8'd79; rows_reg = 6'd23; seed_reg = 32'd1; carve_lfsr = 32'd1;
        foreach (grid_shadow[i]) grid_shadow[i] = 1'b0;
        mismatches = 0; failed = 1'b0; hold_off_cycles = 0;
        send_idle_pct = 16; recv_idle_pct = 54;
        @(posedge aclk);
        test_directed();
        test_random_mazes(16);
        send_idle_pct = 54; recv_idle_pct = 16;
        test_random_mazes(16);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_mazes(12);
        test_backpressure();
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

>>> maze_backtracker_generator.f
+incdir+hw/rtl
hw/rtl/mbg_pkg.sv
hw/rtl/maze_backtracker_generator.sv
test/tb_maze_backtracker_generator.sv
